// File: rtl/core/rrca_pkg.sv
// Shared constants for the reorder receiver with cumulative acknowledgement.
// Used by the channel interfaces and the top level.
package rrca_pkg;

   localparam int WINDOW_MAX_DEF   = 16;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int SEQ_BITS_MAX_DEF = 16;

   localparam int SEQ_W      = 16;
   localparam int CFG_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_BITS    = 1'b1;

   localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd4;
   localparam logic [CFG_W-1:0] SEQ_BITS_RESET    = 5'd16;

   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

endpackage

// File: rtl/core/rrca_req_if.sv
// Packet channel into the receiver: valid/ready plus sequence, checksum flag, payload.
// Depends on rrca_pkg.
interface rrca_req_if #(
   parameter int PAYLOAD_BITS = rrca_pkg::PAYLOAD_BITS_DEF
);
   import rrca_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SEQ_W-1:0]        seq_num;
   logic                    checksum_ok;
   logic [PAYLOAD_BITS-1:0] payload_word;

   modport source (output valid, output seq_num, output checksum_ok, output payload_word,
                   input ready);
   modport sink   (input valid, input seq_num, input checksum_ok, input payload_word,
                   output ready);
endinterface

// File: rtl/core/rrca_rsp_if.sv
// Result channel out of the receiver: deliveries and acknowledgements.
// Depends on rrca_pkg.
interface rrca_rsp_if #(
   parameter int PAYLOAD_BITS = rrca_pkg::PAYLOAD_BITS_DEF
);
   import rrca_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [PAYLOAD_BITS-1:0] delivered_word;
   logic [SEQ_W-1:0]        ack_num;
   logic                    last;

   modport source (output valid, output kind, output delivered_word, output ack_num,
                   output last, input ready);
   modport sink   (input valid, input kind, input delivered_word, input ack_num,
                   input last, output ready);
endinterface

// File: rtl/core/rrca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
)(
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/reorder_receiver_cumulative_ack_top.sv
// Reorder receiver with cumulative acknowledgement: top level.
// Depends on rrca_pkg, rrca_req_if, rrca_rsp_if and rrca_ram.
//
// Usage:
//   req_chan carries one packet per transaction (seq_num, checksum_ok, payload_word).
//   rsp_chan carries results: kind 0 delivers a payload in order, kind 1 is an
//   acknowledgement carrying the next expected number; last marks the end of a burst.
//   csr_wen/csr_index/csr_wdata write window_size (index 0) and seq_bits (index 1);
//   write only while the block is idle.
// Sequencing:
//   A dropped or buffered packet is accepted, then evaluated, and gives no result.
//   An out-of-window packet gives one acknowledgement.
//   An in-order packet is delivered; for each buffered packet drained after it the
//   sequencer looks up the valid bit at the ring head, then reads the buffer RAM.
//   One shared adder computes the window offset and advances the expected number.
//   req_chan.ready is high only while the sequencer is idle.
// Reset: expected number and last acknowledgement go to 0, all buffer slots invalid,
//   window_size 4, seq_bits 16. The buffer RAM needs no clearing pass.
// Stall: a result waits in the output register; the sequencer holds until it is taken,
//   and the next packet can be accepted while the final result of a burst waits.
module reorder_receiver_cumulative_ack_top #(
   parameter int WINDOW_MAX   = rrca_pkg::WINDOW_MAX_DEF,
   parameter int PAYLOAD_BITS = rrca_pkg::PAYLOAD_BITS_DEF,
   parameter int SEQ_BITS_MAX = rrca_pkg::SEQ_BITS_MAX_DEF
)(
   input  logic                              clock,
   input  logic                              reset,
   rrca_req_if.sink                          req_chan,
   rrca_rsp_if.source                        rsp_chan,
   input  logic                              csr_wen,
   input  logic [rrca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrca_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rrca_pkg::*;

   localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SLOT_W = IDX_W + 1;
   localparam int SQ_W   = SEQ_BITS_MAX;
   localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
   localparam logic [SLOT_W-1:0] WIN_DEPTH = SLOT_W'(WINDOW_MAX);
   localparam logic [IDX_W-1:0]  HEAD_LAST = IDX_W'(WINDOW_MAX - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EVAL  = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_ACK   = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        window_size_ff, window_size_in;
   logic [CFG_W-1:0]        seq_bits_ff, seq_bits_in;
   logic [SQ_W-1:0]         exp_ff, exp_in;
   logic [SQ_W-1:0]         last_ack_ff, last_ack_in;
   logic [SQ_W-1:0]         seq_ff, seq_in;
   logic                    ok_ff, ok_in;
   logic [PAYLOAD_BITS-1:0] word_ff, word_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [WINDOW_MAX-1:0]   held_valid_ff, held_valid_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [PAYLOAD_BITS-1:0] rsp_word_ff, rsp_word_in;
   logic [SEQ_W-1:0]        rsp_ack_ff, rsp_ack_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [CFG_W-1:0]        eff_bits;
   logic [SQ_W-1:0]         smask;
   logic [SQ_W-1:0]         half;
   logic [31:0]             win_wide;
   logic [WIN_W-1:0]        win;

   logic [SQ_W-1:0]         alu_a, alu_b, alu_res;
   logic                    alu_sub;
   logic [SQ_W-1:0]         exp_m;
   logic                    d_ge_win, d_zero;
   logic [SLOT_W-1:0]       slot_sum, slot_red;
   logic [IDX_W-1:0]        slot_idx, head_next;

   logic                    ram_wen;
   logic [PAYLOAD_BITS-1:0] ram_rdata;
   logic                    accept, out_free;

   rrca_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (slot_idx),
      .wr_data (word_ff),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = rsp_kind_ff;
   assign rsp_chan.delivered_word = rsp_word_ff;
   assign rsp_chan.ack_num        = rsp_ack_ff;
   assign rsp_chan.last           = rsp_last_ff;

   always_comb begin
      if (seq_bits_ff == '0 || 32'(seq_bits_ff) > SEQ_BITS_MAX) begin
         eff_bits = CFG_W'(SEQ_BITS_MAX);
      end else begin
         eff_bits = seq_bits_ff;
      end
      smask = ~({SQ_W{1'b1}} << eff_bits);
      half  = SQ_W'(1) << (eff_bits - CFG_W'(1));
      win_wide = 32'(window_size_ff);
      if (win_wide == 32'd0) begin
         win_wide = 32'd1;
      end
      if (win_wide > 32'(WINDOW_MAX)) begin
         win_wide = 32'(WINDOW_MAX);
      end
      if (win_wide > 32'(half)) begin
         win_wide = 32'(half);
      end
      win = win_wide[WIN_W-1:0];
   end

   assign exp_m = exp_ff & smask;

   always_comb begin
      if (state_ff == ST_LOOK) begin
         alu_a   = exp_m;
         alu_b   = SQ_W'(1);
         alu_sub = 1'b0;
      end else begin
         alu_a   = seq_ff & smask;
         alu_b   = exp_m;
         alu_sub = 1'b1;
      end
      alu_res = (alu_a + (alu_sub ? ~alu_b : alu_b) + SQ_W'(alu_sub)) & smask;
   end

   assign d_ge_win = 32'(alu_res) >= 32'(win);
   assign d_zero   = (alu_res == '0);
   assign slot_sum = SLOT_W'(head_ff) + SLOT_W'(alu_res);
   assign slot_red = (slot_sum >= WIN_DEPTH) ? (slot_sum - WIN_DEPTH) : slot_sum;
   assign slot_idx = slot_red[IDX_W-1:0];
   assign head_next = (head_ff == HEAD_LAST) ? '0 : (head_ff + IDX_W'(1));

   always_comb begin
      state_in       = state_ff;
      window_size_in = window_size_ff;
      seq_bits_in    = seq_bits_ff;
      exp_in         = exp_ff;
      last_ack_in    = last_ack_ff;
      seq_in         = seq_ff;
      ok_in          = ok_ff;
      word_in        = word_ff;
      head_in        = head_ff;
      held_valid_in  = held_valid_ff;
      ram_wen        = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_ack_in     = rsp_ack_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_wen) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_in = csr_wdata;
            CSR_SEQ_BITS:    seq_bits_in    = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seq_in   = req_chan.seq_num[SQ_W-1:0];
               ok_in    = req_chan.checksum_ok;
               word_in  = req_chan.payload_word;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               if (!ok_ff) begin
                  state_in = ST_IDLE;
               end else if (d_ge_win) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_ACK;
                  rsp_word_in  = '0;
                  rsp_ack_in   = SEQ_W'(last_ack_ff);
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else if (!d_zero) begin
                  ram_wen                 = 1'b1;
                  held_valid_in[slot_idx] = 1'b1;
                  state_in                = ST_IDLE;
               end else begin
                  rsp_valid_in           = 1'b1;
                  rsp_kind_in            = KIND_DELIVER;
                  rsp_word_in            = word_ff;
                  rsp_ack_in             = '0;
                  rsp_last_in            = 1'b0;
                  held_valid_in[head_ff] = 1'b0;
                  head_in                = head_next;
                  state_in               = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            exp_in = alu_res;
            if (held_valid_ff[head_ff]) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_FETCH: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_kind_in            = KIND_DELIVER;
               rsp_word_in            = ram_rdata;
               rsp_ack_in             = '0;
               rsp_last_in            = 1'b0;
               held_valid_in[head_ff] = 1'b0;
               head_in                = head_next;
               state_in               = ST_LOOK;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_word_in  = '0;
               rsp_ack_in   = SEQ_W'(exp_ff);
               rsp_last_in  = 1'b1;
               last_ack_in  = exp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_size_ff <= WINDOW_SIZE_RESET;
         seq_bits_ff    <= SEQ_BITS_RESET;
         exp_ff         <= '0;
         last_ack_ff    <= '0;
         head_ff        <= '0;
         held_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         seq_bits_ff    <= seq_bits_in;
         exp_ff         <= exp_in;
         last_ack_ff    <= last_ack_in;
         head_ff        <= head_in;
         held_valid_ff  <= held_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      ok_ff       <= ok_in;
      word_ff     <= word_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_word_ff <= rsp_word_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EVAL)
      else $error("accepted transaction not evaluated next cycle");

   a_fetch_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> held_valid_ff[head_ff])
      else $error("fetch from an invalid buffer slot");

   a_ack_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACK && out_free)
         |=> (rsp_chan.valid && rsp_chan.kind == KIND_ACK && rsp_chan.last))
      else $error("burst not closed by an acknowledgement");

   a_deliver_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == KIND_DELIVER) |-> !rsp_chan.last)
      else $error("delivery marked as last");

   a_idle_ack_sync: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> last_ack_ff == exp_ff)
      else $error("last acknowledgement differs from expected number while idle");

endmodule
